### sv/sads_pkg.sv
`timescale 1ns / 1ps
// Shared definitions for the dual-stack unit: request and status codes,
// field widths, default sizes and the result packing function. No dependencies.
package sads_pkg;

    localparam int DEPTH_DEFAULT      = 64;
    localparam int DATA_WIDTH_DEFAULT = 32;
    localparam int CAP_RESET          = 64;

    // Fixed field widths of the stream payloads
    localparam int KIND_W     = 3;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int FOUND_W    = 6;
    localparam int COUNT_W    = 7;
    localparam int CAP_W      = 7;
    localparam int IN_TUSER_W = 4;
    localparam int OUT_DATA_W = 56;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_PUSH   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_POP    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd3;

    // Pack one result, lowest field first, one pad bit on top
    function automatic logic [OUT_DATA_W-1:0] pack_result(
        input logic [STATUS_W-1:0] status,
        input logic [VALUE_W-1:0]  data,
        input logic [FOUND_W-1:0]  found_index,
        input logic [COUNT_W-1:0]  count_a,
        input logic [COUNT_W-1:0]  count_b,
        input logic                is_full
    );
        return {1'b0, is_full, count_b, count_a, found_index, data, status};
    endfunction

endpackage

### sv/sads_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sads_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/shared_array_dual_stack_unit.sv
`timescale 1ns / 1ps
// Two stacks in one shared slot RAM: sequencer, capacity register, output register.
// Depends on sads_pkg and sads_ram.
//
// Usage:
//   Requests arrive on the s_ channel: s_tuser carries the kind (push, pop, peek,
//   clear, search) and the stack select, s_tdata the 32-bit value. Every request
//   gives exactly one result on the m_ channel: status, data, match slot, both
//   stack sizes and a full flag. Stack A grows up from slot 0, stack B down from
//   slot capacity-1; a push is refused only when every slot in use is taken.
//   cfg_wr_en/cfg_wr_data set the capacity in use (clamped to 2..DEPTH) and empty
//   both stacks; write it only while no request is in flight.
// Timing:
//   Pop and peek of a non-empty stack go through ST_READ, all other requests through
//   ST_DONE, to the output register; the next request is taken only once that result
//   is handed on. A pop or peek reads the slot at the accept edge and sends the
//   registered data straight on. A search walks the stack one slot per cycle from
//   its bottom, stops at the first match or at the top and then waits in ST_DONE;
//   s_tready returns high in the same cycle as m_tvalid rises.
// Reset and stall:
//   Reset empties both stacks and sets capacity 64 (or DEPTH if smaller); slot
//   contents are not cleared. One result waits in the output register while the
//   next request is worked on; that next result holds in the sequencer until the
//   output register frees up, and s_tready stays low until then.
module shared_array_dual_stack_unit
    import sads_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEFAULT,
    parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration
    input  logic                  cfg_wr_en,
    input  logic [CAP_W-1:0]      cfg_wr_data,   // capacity_in_use
    // Request channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [VALUE_W-1:0]    s_tdata,       // [31:0] value
    input  logic [IN_TUSER_W-1:0] s_tuser,       // [2:0] kind, [3] which_stack
    // Result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [1:0] status, [33:2] data, [39:34] found_index, [46:40] count_a,
    // [53:47] count_b, [54] is_full, [55] zero
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int AW      = $clog2(DEPTH);
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int CX      = (CW > CAP_W) ? CW : CAP_W;
    localparam int CAP_RST = (DEPTH < CAP_RESET) ? DEPTH : CAP_RESET;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t                state_reg;
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [CW-1:0]         cap_reg;
    logic [CW-1:0]         depth_a_reg;
    logic [CW-1:0]         depth_b_reg;
    logic                  on_b_reg;
    logic [DATA_WIDTH-1:0] key_reg;
    logic [CW-1:0]         scan_k_reg;
    logic [AW-1:0]         scan_slot_reg;
    logic [STATUS_W-1:0]   res_status_reg;
    logic [VALUE_W-1:0]    res_data_reg;
    logic [AW-1:0]         res_found_reg;

    // Request decode
    logic [KIND_W-1:0]             s_kind;
    logic                          s_on_b;
    logic                          s_accept;
    logic [DATA_WIDTH+VALUE_W-1:0] val_sx;
    logic [DATA_WIDTH-1:0]         s_stored;

    assign s_kind   = s_tuser[KIND_W-1:0];
    assign s_on_b   = s_tuser[KIND_W];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    // Sign extend the 32-bit value, then keep the stored width
    assign val_sx   = {{DATA_WIDTH{s_tdata[VALUE_W-1]}}, s_tdata};
    assign s_stored = val_sx[DATA_WIDTH-1:0];

    // Stack geometry
    logic [CW:0]   depth_sum;
    logic          full_now;
    logic [CW-1:0] sel_depth;
    logic [CW-1:0] push_slot;
    logic [CW-1:0] top_slot;
    logic          scan_b;
    logic [CW-1:0] scan_k;
    logic [CW-1:0] scan_slot;
    logic [CW-1:0] scan_n;

    assign depth_sum = {1'b0, depth_a_reg} + {1'b0, depth_b_reg};
    assign full_now  = (depth_sum >= {1'b0, cap_reg});
    assign sel_depth = s_on_b ? depth_b_reg : depth_a_reg;
    assign push_slot = s_on_b ? (cap_reg - CW'(1) - depth_b_reg) : depth_a_reg;
    assign top_slot  = s_on_b ? (cap_reg - depth_b_reg) : (depth_a_reg - CW'(1));
    // Scan position: element 0 on accept, then walk with the counter
    assign scan_b    = (state_reg == ST_SCAN) ? on_b_reg : s_on_b;
    assign scan_k    = (state_reg == ST_SCAN) ? scan_k_reg : '0;
    assign scan_slot = scan_b ? (cap_reg - CW'(1) - scan_k) : scan_k;
    assign scan_n    = on_b_reg ? depth_b_reg : depth_a_reg;

    // Slot RAM
    logic                  ram_we;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    assign ram_we    = s_accept && (s_kind == KIND_PUSH) && !full_now;
    assign ram_raddr = ((state_reg == ST_IDLE) &&
                        ((s_kind == KIND_POP) || (s_kind == KIND_PEEK)))
                       ? top_slot[AW-1:0] : scan_slot[AW-1:0];

    sads_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_slots (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (push_slot[AW-1:0]),
        .wr_data (s_stored),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Read data sign extended back to 32 bits
    logic [DATA_WIDTH+VALUE_W-1:0] rd_sx;
    logic [VALUE_W-1:0]            rd_word;
    logic                          hit;

    assign rd_sx   = {{VALUE_W{ram_rdata[DATA_WIDTH-1]}}, ram_rdata};
    assign rd_word = rd_sx[VALUE_W-1:0];
    assign hit     = (ram_rdata == key_reg);

    // Capacity clamp
    logic [CX-1:0] cfg_x;
    logic [CW-1:0] cap_next;

    assign cfg_x = CX'(cfg_wr_data);

    always_comb begin
        priority if (cfg_x < CX'(2)) begin
            cap_next = CW'(2);
        end else if (cfg_x > CX'(DEPTH)) begin
            cap_next = CW'(DEPTH);
        end else begin
            cap_next = cfg_x[CW-1:0];
        end
    end

    // Result emission
    logic                  out_free;
    logic                  emit_go;
    logic [STATUS_W-1:0]   emit_status;
    logic [VALUE_W-1:0]    emit_data;
    logic [AW+FOUND_W-1:0] found_x;
    logic [CW+COUNT_W-1:0] count_a_x;
    logic [CW+COUNT_W-1:0] count_b_x;
    logic [OUT_DATA_W-1:0] m_tdata_next;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        emit_go     = 1'b0;
        emit_status = res_status_reg;
        emit_data   = res_data_reg;
        unique case (state_reg)
            ST_DONE: begin
                emit_go = out_free;
            end
            ST_READ: begin
                // Forward the returning slot straight into the output register
                emit_go     = out_free;
                emit_status = STAT_OK;
                emit_data   = rd_word;
            end
            default: ;
        endcase
    end

    assign found_x   = {{FOUND_W{1'b0}}, res_found_reg};
    assign count_a_x = {{COUNT_W{1'b0}}, depth_a_reg};
    assign count_b_x = {{COUNT_W{1'b0}}, depth_b_reg};
    assign m_tdata_next = pack_result(emit_status, emit_data,
                                      (state_reg == ST_READ) ? '0 : found_x[FOUND_W-1:0],
                                      count_a_x[COUNT_W-1:0], count_b_x[COUNT_W-1:0],
                                      full_now);

    // Sequencer, stack pointers and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            cap_reg      <= CW'(CAP_RST);
            depth_a_reg  <= '0;
            depth_b_reg  <= '0;
        end else begin
            if (emit_go) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= m_tdata_next;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            // Stack B's slots move with the capacity: drop both stacks
            if (cfg_wr_en) begin
                cap_reg     <= cap_next;
                depth_a_reg <= '0;
                depth_b_reg <= '0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        on_b_reg       <= s_on_b;
                        key_reg        <= s_stored;
                        res_status_reg <= STAT_OK;
                        res_data_reg   <= '0;
                        res_found_reg  <= '0;
                        state_reg      <= ST_DONE;
                        unique case (s_kind)
                            KIND_PUSH: begin
                                if (full_now) begin
                                    res_status_reg <= STAT_FULL;
                                end else if (s_on_b) begin
                                    depth_b_reg <= depth_b_reg + CW'(1);
                                end else begin
                                    depth_a_reg <= depth_a_reg + CW'(1);
                                end
                            end
                            KIND_POP, KIND_PEEK: begin
                                if (sel_depth == '0) begin
                                    res_status_reg <= STAT_EMPTY;
                                end else begin
                                    state_reg <= ST_READ;
                                    if (s_kind == KIND_POP) begin
                                        if (s_on_b) begin
                                            depth_b_reg <= depth_b_reg - CW'(1);
                                        end else begin
                                            depth_a_reg <= depth_a_reg - CW'(1);
                                        end
                                    end
                                end
                            end
                            KIND_CLEAR: begin
                                if (s_on_b) begin
                                    depth_b_reg <= '0;
                                end else begin
                                    depth_a_reg <= '0;
                                end
                            end
                            KIND_SEARCH: begin
                                if (sel_depth == '0) begin
                                    res_status_reg <= STAT_NOTFOUND;
                                end else begin
                                    state_reg     <= ST_SCAN;
                                    scan_slot_reg <= scan_slot[AW-1:0];
                                    scan_k_reg    <= CW'(1);
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_READ: begin
                    // Hold the read data when the output register is still busy
                    if (emit_go) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        res_data_reg <= rd_word;
                        state_reg    <= ST_DONE;
                    end
                end
                ST_SCAN: begin
                    // Walk from the bottom of the stack: first hit is the wanted slot
                    priority if (hit) begin
                        res_found_reg <= scan_slot_reg;
                        state_reg     <= ST_DONE;
                    end else if (scan_k_reg == scan_n) begin
                        res_status_reg <= STAT_NOTFOUND;
                        state_reg      <= ST_DONE;
                    end else begin
                        scan_slot_reg <= scan_slot[AW-1:0];
                        scan_k_reg    <= scan_k_reg + CW'(1);
                    end
                end
                ST_DONE: begin
                    if (emit_go) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_sum <= {1'b0, cap_reg})
        else $error("stacks overlap the capacity in use");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("request accepted while another is in flight");

    a_read_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |-> $past(s_accept))
        else $error("slot read state entered without a request");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> ((scan_n != '0) && (scan_k_reg <= scan_n)))
        else $error("search walked past the top of the stack");

endmodule

### tb/shared_array_dual_stack_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the two-stacks-in-one-array unit: an in-bench model predicts
// every result, which is compared with the m_ stream. Depends on sads_pkg and the unit.
module shared_array_dual_stack_unit_tb;
    import sads_pkg::*;

    localparam logic STACK_A = 1'b0;
    localparam logic STACK_B = 1'b1;
    localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = KIND_SEARCH + 3'd1;
    localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;
    localparam int SEARCH_SETTLE = 80;   // longest search plus margin

    // Fields from the top bit down, so the struct maps onto m_tdata[54:0]
    typedef struct packed {
        logic                is_full;
        logic [COUNT_W-1:0]  count_b;
        logic [COUNT_W-1:0]  count_a;
        logic [FOUND_W-1:0]  found_index;
        logic [VALUE_W-1:0]  data;
        logic [STATUS_W-1:0] status;
    } stack_result_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CAP_W-1:0]      cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [VALUE_W-1:0]    s_tdata     = '0;
    logic [IN_TUSER_W-1:0] s_tuser     = '0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    // Shadow copy of the unit's state
    logic [VALUE_W-1:0] model_slots [DEPTH_DEFAULT];
    int                 model_count_a = 0;
    int                 model_count_b = 0;
    logic [CAP_W-1:0]   model_capacity = 7'(CAP_RESET);

    stack_result_t pending_results[$];
    int            mismatch_count = 0;

    bit sender_idles   = 1'b1;
    bit receiver_idles = 1'b1;
    bit hold_off       = 1'b0;
    int stall_left     = 0;

    shared_array_dual_stack_unit u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    always #10 aclk = ~aclk;

    initial begin
        #20_000_000;
        $display("shared_array_dual_stack_unit: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic int active_capacity();
        int cap;
        cap = int'(model_capacity);
        if (cap < 2) cap = 2;
        if (cap > DEPTH_DEFAULT) cap = DEPTH_DEFAULT;
        return cap;
    endfunction

    function automatic stack_result_t predict_stack_step(input logic [KIND_W-1:0] kind,
                                                         input logic which,
                                                         input logic [VALUE_W-1:0] value);
        stack_result_t r;
        int cap;
        int top;
        int found_slot;
        int fill;
        r = '0;
        found_slot = 0;
        cap = active_capacity();
        case (kind)
            KIND_PUSH: begin
                if (model_count_a + model_count_b >= cap) begin
                    r.status = STAT_FULL;
                end else if (which == STACK_B) begin
                    model_slots[cap - 1 - model_count_b] = value;
                    model_count_b++;
                end else begin
                    model_slots[model_count_a] = value;
                    model_count_a++;
                end
            end
            KIND_POP, KIND_PEEK: begin
                fill = (which == STACK_B) ? model_count_b : model_count_a;
                if (fill == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    top = (which == STACK_B) ? cap - model_count_b : model_count_a - 1;
                    r.data = model_slots[top];
                    if (kind == KIND_POP) begin
                        if (which == STACK_B) model_count_b--;
                        else model_count_a--;
                    end
                end
            end
            KIND_CLEAR: begin
                if (which == STACK_B) model_count_b = 0;
                else model_count_a = 0;
            end
            KIND_SEARCH: begin
                // A scans up from its bottom, B down from its bottom: first hit wins
                r.status = STAT_NOTFOUND;
                if (which == STACK_B) begin
                    for (int i = 0; i < model_count_b && r.status == STAT_NOTFOUND; i++) begin
                        if (model_slots[cap - 1 - i] == value) begin
                            r.status = STAT_OK;
                            found_slot = cap - 1 - i;
                        end
                    end
                end else begin
                    for (int i = 0; i < model_count_a && r.status == STAT_NOTFOUND; i++) begin
                        if (model_slots[i] == value) begin
                            r.status = STAT_OK;
                            found_slot = i;
                        end
                    end
                end
            end
            default: ;   // spare kinds change nothing
        endcase
        r.found_index = found_slot[FOUND_W-1:0];
        r.count_a     = model_count_a[COUNT_W-1:0];
        r.count_b     = model_count_b[COUNT_W-1:0];
        r.is_full     = (model_count_a + model_count_b >= cap);
        return r;
    endfunction

    // Track capacity writes and accepted requests
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en) begin
                model_capacity = cfg_wr_data;
                model_count_a  = 0;
                model_count_b  = 0;
            end
            if (s_tvalid && s_tready)
                pending_results.push_back(predict_stack_step(s_tuser[KIND_W-1:0],
                                                             s_tuser[KIND_W], s_tdata));
        end
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input stack_result_t want,
                                   input stack_result_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%t %s: status %0d/%0d data %h/%h found %0d/%0d",
                     $realtime, what, want.status, got.status, want.data, got.data,
                     want.found_index, got.found_index,
                     " count_a %0d/%0d count_b %0d/%0d full %0d/%0d (expected/actual)",
                     want.count_a, got.count_a, want.count_b, got.count_b,
                     want.is_full, got.is_full);
    endtask

    always @(posedge aclk) begin : check_result
        stack_result_t got;
        stack_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = stack_result_t'(m_tdata[$bits(stack_result_t)-1:0]);
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", '0, got);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.data !== want.data ||
                    got.found_index !== want.found_index || got.count_a !== want.count_a ||
                    got.count_b !== want.count_b || got.is_full !== want.is_full)
                    report_mismatch("result differs", want, got);
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, plus a long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_off) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (receiver_idles && $urandom_range(0, 7) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= int'($urandom_range(1, 16)) - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    task automatic offer_request(input logic [KIND_W-1:0] kind, input logic which,
                                 input logic [VALUE_W-1:0] value);
        int gap;
        if (sender_idles && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {which, kind};
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Drop valid and hold until every pending result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0, 1:    return VALUE_W'($urandom_range(0, 3));   // small pool for repeats
            2: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'hFFFF_FFFF;
                    default: return 32'h0000_0000;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // One request, weighted toward pushes so the stacks fill and meet
    task automatic random_request();
        int roll;
        int cap;
        logic which;
        logic [KIND_W-1:0] kind;
        logic [VALUE_W-1:0] value;
        roll  = $urandom_range(0, 99);
        which = 1'($urandom_range(0, 1));
        value = pick_value();
        cap   = active_capacity();
        if (roll < 45)      kind = KIND_PUSH;
        else if (roll < 63) kind = KIND_POP;
        else if (roll < 73) kind = KIND_PEEK;
        else if (roll < 93) kind = KIND_SEARCH;
        else if (roll < 96) kind = KIND_CLEAR;
        else                kind = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
        // Half the searches look for a value that is really on the stack
        if (kind == KIND_SEARCH && $urandom_range(0, 1) == 1) begin
            if (which == STACK_B && model_count_b > 0)
                value = model_slots[cap - 1 - int'($urandom_range(0, model_count_b - 1))];
            else if (which == STACK_A && model_count_a > 0)
                value = model_slots[int'($urandom_range(0, model_count_a - 1))];
        end
        offer_request(kind, which, value);
    endtask

    task automatic run_random_requests(input int count);
        for (int n = 0; n < count; n++) random_request();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_cases();
        offer_request(KIND_POP, STACK_A, 32'h0);           // empty pops and peeks
        offer_request(KIND_POP, STACK_B, 32'h0);
        offer_request(KIND_PEEK, STACK_A, 32'h0);
        offer_request(KIND_PEEK, STACK_B, 32'h0);
        offer_request(KIND_SEARCH, STACK_A, 32'h0);        // search on empty stacks
        offer_request(KIND_SEARCH, STACK_B, 32'h0);
        offer_request(KIND_PUSH, STACK_A, 32'h7FFF_FFFF);
        offer_request(KIND_PUSH, STACK_A, 32'h8000_0000);
        offer_request(KIND_PUSH, STACK_B, 32'h0000_0000);
        offer_request(KIND_PUSH, STACK_B, 32'hFFFF_FFFF);
        offer_request(KIND_PEEK, STACK_A, 32'h0);
        offer_request(KIND_PEEK, STACK_B, 32'h0);
        offer_request(KIND_SEARCH, STACK_A, 32'h7FFF_FFFF);
        offer_request(KIND_SEARCH, STACK_B, 32'h0000_0000);
        offer_request(KIND_SEARCH, STACK_A, 32'h1234_5678); // miss
        for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++)
            offer_request(3'(k), 1'(k), 32'hA5A5_5A5A);
        offer_request(KIND_CLEAR, STACK_B, 32'h0);
        offer_request(KIND_POP, STACK_B, 32'h0);
        offer_request(KIND_POP, STACK_A, 32'h0);
        offer_request(KIND_POP, STACK_A, 32'h0);
        offer_request(KIND_POP, STACK_A, 32'h0);
        offer_request(KIND_CLEAR, STACK_A, 32'h0);
    endtask

    // Smallest capacity: two pushes fill it, the third is refused
    task automatic test_smallest_capacity();
        write_capacity(7'd2);
        offer_request(KIND_PUSH, STACK_A, 32'h0000_0011);
        offer_request(KIND_PUSH, STACK_B, 32'h0000_0022);
        offer_request(KIND_PUSH, STACK_A, 32'h0000_0033);
        offer_request(KIND_PUSH, STACK_B, 32'h0000_0044);
        offer_request(KIND_POP, STACK_B, 32'h0);
        offer_request(KIND_PUSH, STACK_B, 32'h0000_0055);
        offer_request(KIND_PEEK, STACK_B, 32'h0);
        write_capacity(7'd0);                              // clamps to 2
        offer_request(KIND_PUSH, STACK_B, 32'hDEAD_BEEF);
        offer_request(KIND_PUSH, STACK_B, 32'hCAFE_F00D);
        offer_request(KIND_PUSH, STACK_A, 32'h1);
        offer_request(KIND_SEARCH, STACK_B, 32'hDEAD_BEEF);
    endtask

    // Repeated values: A reports the lowest slot, B the highest
    task automatic test_repeated_values();
        write_capacity(7'd8);
        repeat (3) offer_request(KIND_PUSH, STACK_A, 32'h0000_0005);
        repeat (3) offer_request(KIND_PUSH, STACK_B, 32'h0000_0005);
        offer_request(KIND_SEARCH, STACK_A, 32'h0000_0005);
        offer_request(KIND_SEARCH, STACK_B, 32'h0000_0005);
        offer_request(KIND_PUSH, STACK_A, 32'h0000_0006);
        offer_request(KIND_PUSH, STACK_B, 32'h0000_0006);
        offer_request(KIND_PUSH, STACK_B, 32'h0000_0007);
        offer_request(KIND_SEARCH, STACK_B, 32'h0000_0006);
        offer_request(KIND_SEARCH, STACK_A, 32'h0000_0006);
    endtask

    // Largest capacity, written out of range: fill all 64 slots, then scan deep
    task automatic test_fill_largest();
        write_capacity(7'd127);
        repeat (40) offer_request(KIND_PUSH, STACK_A, $urandom);
        repeat (24) offer_request(KIND_PUSH, STACK_B, $urandom);
        offer_request(KIND_PUSH, STACK_A, 32'h1);
        offer_request(KIND_PUSH, STACK_B, 32'h1);
        offer_request(KIND_SEARCH, STACK_A, model_slots[39]);
        offer_request(KIND_SEARCH, STACK_B, model_slots[40]);
        offer_request(KIND_SEARCH, STACK_A, 32'hFFFF_FFFE);
        offer_request(KIND_SEARCH, STACK_B, 32'hFFFF_FFFE);
    endtask

    task automatic test_random_capacities();
        int unsigned caps[12] = '{1, 3, 5, 64, 9, 2, 17, 65, 33, 4, 127, 0};
        foreach (caps[i]) begin
            write_capacity(7'(caps[i]));
            run_random_requests(45);
        end
    endtask

    // Hold the receiver off long enough that the unit fills and stalls its input
    task automatic test_backpressure();
        write_capacity(7'd12);
        fork
            begin
                hold_off <= 1'b1;
                repeat (120) @(posedge aclk);
                hold_off <= 1'b0;
            end
        join_none
        sender_idles = 1'b0;
        run_random_requests(30);
        sender_idles = 1'b1;
    endtask

    task automatic test_full_rate();
        write_capacity(7'd20);
        sender_idles   =  1'b0;
        receiver_idles <= 1'b0;
        run_random_requests(80);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_smallest_capacity();
        test_repeated_values();
        test_fill_largest();
        test_random_capacities();
        test_backpressure();
        test_full_rate();

        drain_results();
        repeat (SEARCH_SETTLE) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $display("%0d results never arrived", pending_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("shared_array_dual_stack_unit: match");
        else
            $display("shared_array_dual_stack_unit: mismatch");
        $finish;
    end

endmodule
